### rtl/uwsc_pkg.sv
// Package for the UTF-8 word script classifier.
// Holds the per-word decode state type, result codes and code point ranges.
// No dependencies.
package uwsc_pkg;

   typedef struct packed {
      logic [1:0]  bytes_pending;
      logic [1:0]  sequence_length;
      logic [20:0] partial_codepoint;
      logic        seen_hiragana;
      logic        seen_katakana;
      logic        seen_other;
      logic        bad_seen;
   } word_state_type;

   localparam word_state_type WORD_STATE_CLEAR = '0;

   localparam logic [1:0] CLASS_HIRAGANA = 2'd0;
   localparam logic [1:0] CLASS_KATAKANA = 2'd1;
   localparam logic [1:0] CLASS_OTHER    = 2'd2;

   localparam logic [1:0] CP_HIRAGANA = 2'd0;
   localparam logic [1:0] CP_KATAKANA = 2'd1;
   localparam logic [1:0] CP_OTHER    = 2'd2;
   localparam logic [1:0] CP_MARK     = 2'd3;

   localparam logic [20:0] HIRAGANA_LO   = 21'h003040;
   localparam logic [20:0] HIRAGANA_HI   = 21'h00309F;
   localparam logic [20:0] KATAKANA_LO   = 21'h0030A0;
   localparam logic [20:0] KATAKANA_HI   = 21'h0030FF;
   localparam logic [20:0] KATAKANA_EXT_LO = 21'h0031F0;
   localparam logic [20:0] KATAKANA_EXT_HI = 21'h0031FF;
   localparam logic [20:0] HALFWIDTH_LO  = 21'h00FF65;
   localparam logic [20:0] HALFWIDTH_HI  = 21'h00FF9F;
   localparam logic [20:0] PROLONGED_MARK = 21'h0030FC;
   localparam logic [20:0] MIN_TWO_BYTE   = 21'h000080;
   localparam logic [20:0] MIN_THREE_BYTE = 21'h000800;
   localparam logic [20:0] MIN_FOUR_BYTE  = 21'h010000;
   localparam logic [20:0] SURROGATE_LO   = 21'h00D800;
   localparam logic [20:0] SURROGATE_HI   = 21'h00DFFF;
   localparam logic [20:0] MAX_CODEPOINT  = 21'h10FFFF;

   function automatic logic [1:0] classify_cp(input logic [20:0] cp);
      logic [1:0] kind;
      if (cp == PROLONGED_MARK) begin
         kind = CP_MARK;
      end else if (cp inside {[HIRAGANA_LO:HIRAGANA_HI]}) begin
         kind = CP_HIRAGANA;
      end else if (cp inside {[KATAKANA_LO:KATAKANA_HI], [KATAKANA_EXT_LO:KATAKANA_EXT_HI],
                              [HALFWIDTH_LO:HALFWIDTH_HI]}) begin
         kind = CP_KATAKANA;
      end else begin
         kind = CP_OTHER;
      end
      return kind;
   endfunction

endpackage

### rtl/uwsc_decode.sv
// Byte step of the UTF-8 decoder: next word state and the word result.
// Depends on uwsc_pkg for the state type, ranges and class codes.
module uwsc_decode (
   input  uwsc_pkg::word_state_type cur_state,
   input  logic [7:0]               text_byte,
   input  logic                     word_end,
   output uwsc_pkg::word_state_type next_state,
   output logic [1:0]               script_class,
   output logic                     bad_encoding
);

   uwsc_pkg::word_state_type st;
   logic [1:0]  kind;
   logic        cp_ok;

   always_comb begin
      st    = cur_state;
      kind  = uwsc_pkg::CP_MARK;
      cp_ok = 1'b1;
      if (text_byte[7:6] == 2'b10) begin
         if (st.bytes_pending == 2'd0) begin
            st.bad_seen   = 1'b1;
            st.seen_other = 1'b1;
         end else begin
            st.partial_codepoint = {st.partial_codepoint[14:0], text_byte[5:0]};
            st.bytes_pending     = st.bytes_pending - 2'd1;
            if (st.bytes_pending == 2'd0) begin
               case (st.sequence_length)
                  2'd1: cp_ok = st.partial_codepoint >= uwsc_pkg::MIN_TWO_BYTE;
                  2'd2: cp_ok = (st.partial_codepoint >= uwsc_pkg::MIN_THREE_BYTE) &&
                                !(st.partial_codepoint inside
                                  {[uwsc_pkg::SURROGATE_LO:uwsc_pkg::SURROGATE_HI]});
                  default: cp_ok = (st.partial_codepoint >= uwsc_pkg::MIN_FOUR_BYTE) &&
                                   (st.partial_codepoint <= uwsc_pkg::MAX_CODEPOINT);
               endcase
               if (cp_ok) begin
                  kind = uwsc_pkg::classify_cp(st.partial_codepoint);
               end else begin
                  st.bad_seen   = 1'b1;
                  st.seen_other = 1'b1;
               end
               st.sequence_length   = 2'd0;
               st.partial_codepoint = '0;
            end
         end
      end else begin
         if (st.bytes_pending != 2'd0) begin
            st.bad_seen          = 1'b1;
            st.seen_other        = 1'b1;
            st.bytes_pending     = 2'd0;
            st.sequence_length   = 2'd0;
            st.partial_codepoint = '0;
         end
         if (text_byte[7] == 1'b0) begin
            kind = uwsc_pkg::classify_cp({13'd0, text_byte});
         end else if (text_byte[7:5] == 3'b110) begin
            st.bytes_pending     = 2'd1;
            st.sequence_length   = 2'd1;
            st.partial_codepoint = {16'd0, text_byte[4:0]};
         end else if (text_byte[7:4] == 4'b1110) begin
            st.bytes_pending     = 2'd2;
            st.sequence_length   = 2'd2;
            st.partial_codepoint = {17'd0, text_byte[3:0]};
         end else if (text_byte[7:3] == 5'b11110) begin
            st.bytes_pending     = 2'd3;
            st.sequence_length   = 2'd3;
            st.partial_codepoint = {18'd0, text_byte[2:0]};
         end else begin
            st.bad_seen   = 1'b1;
            st.seen_other = 1'b1;
         end
      end

      case (kind)
         uwsc_pkg::CP_HIRAGANA: st.seen_hiragana = 1'b1;
         uwsc_pkg::CP_KATAKANA: st.seen_katakana = 1'b1;
         uwsc_pkg::CP_OTHER:    st.seen_other    = 1'b1;
         default:               st.seen_other    = st.seen_other;
      endcase

      if (word_end && (st.bytes_pending != 2'd0)) begin
         st.bad_seen   = 1'b1;
         st.seen_other = 1'b1;
      end

      if (!st.seen_other && st.seen_hiragana && !st.seen_katakana) begin
         script_class = uwsc_pkg::CLASS_HIRAGANA;
      end else if (!st.seen_other && st.seen_katakana && !st.seen_hiragana) begin
         script_class = uwsc_pkg::CLASS_KATAKANA;
      end else begin
         script_class = uwsc_pkg::CLASS_OTHER;
      end
      bad_encoding = st.bad_seen;

      next_state = word_end ? uwsc_pkg::WORD_STATE_CLEAR : st;
   end

endmodule

### rtl/utf8_word_script_classifier.sv
// Top level of the UTF-8 word script classifier: state and result registers.
// Depends on uwsc_pkg and uwsc_decode.
//
//   channel   direction   handshake             payload
//   req       in          req_valid/req_stall   req_text_byte, req_word_end
//   rsp       out         rsp_valid/rsp_stall   rsp_script_class, rsp_bad_encoding
//
// One byte per cycle while not stalled; results appear the cycle after each word end.
// Each byte is decoded combinationally against the word state register.
// Reset clears the word state and the result valid flag.
// Input is stalled only while a result is held and the output side stalls.
module utf8_word_script_classifier (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   input  logic       req_word_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_script_class,
   output logic       rsp_bad_encoding
);

   uwsc_pkg::word_state_type state_ff;
   uwsc_pkg::word_state_type state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [1:0] class_ff;
   logic [1:0] class_in;
   logic       bad_ff;
   logic       bad_in;
   logic       req_take;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   uwsc_decode u_decode (
      .cur_state    (state_ff),
      .text_byte    (req_text_byte),
      .word_end     (req_word_end),
      .next_state   (state_in),
      .script_class (class_in),
      .bad_encoding (bad_in)
   );

   always_comb begin
      if (req_take && req_word_end) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= uwsc_pkg::WORD_STATE_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && req_word_end) begin
         class_ff <= class_in;
         bad_ff   <= bad_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_script_class = class_ff;
   assign rsp_bad_encoding = bad_ff;

endmodule

### test/tb.sv
// Testbench for utf8_word_script_classifier: streams directed and random UTF-8 words
// through the byte channel and checks each word verdict against a built-in predictor.
// Depends on uwsc_pkg and the classifier RTL.
`timescale 1ns / 1ps

module tb;

   typedef struct {
      logic [1:0] script_class;
      logic       bad_encoding;
   } word_verdict_type;

   typedef enum int {GROUP_HIRA, GROUP_KATA, GROUP_MARK, GROUP_MIXED} cp_group_type;

   typedef enum int {
      FAULT_NONE, FAULT_STRAY, FAULT_BAD_LEAD, FAULT_INTERRUPT, FAULT_OVERLONG,
      FAULT_SURROGATE, FAULT_ABOVE_MAX, FAULT_CUT_SHORT, FAULT_NOISE
   } fault_kind_type;

   localparam int HOLD_CYCLES  = 80;
   localparam int RANDOM_BYTES = 1600;

   class word_class_scoreboard;
      word_verdict_type expected_words[$];
      logic [1:0]       pend_cnt;
      logic [1:0]       seq_len;
      logic [20:0]      cp_acc;
      bit               got_hira;
      bit               got_kata;
      bit               got_other;
      bit               got_bad;
      int               mismatch_count;

      function new();
         reset_word();
         mismatch_count = 0;
      endfunction

      function void reset_word();
         pend_cnt  = '0;
         seq_len   = '0;
         cp_acc    = '0;
         got_hira  = 1'b0;
         got_kata  = 1'b0;
         got_other = 1'b0;
         got_bad   = 1'b0;
      endfunction

      function void flag_malformed();
         got_bad   = 1'b1;
         got_other = 1'b1;
      endfunction

      function void sort_cp(logic [20:0] cp);
         if (cp == uwsc_pkg::PROLONGED_MARK) begin
            return;
         end
         if (cp >= uwsc_pkg::HIRAGANA_LO && cp <= uwsc_pkg::HIRAGANA_HI) begin
            got_hira = 1'b1;
         end else if ((cp >= uwsc_pkg::KATAKANA_LO && cp <= uwsc_pkg::KATAKANA_HI) ||
                      (cp >= uwsc_pkg::KATAKANA_EXT_LO &&
                       cp <= uwsc_pkg::KATAKANA_EXT_HI) ||
                      (cp >= uwsc_pkg::HALFWIDTH_LO && cp <= uwsc_pkg::HALFWIDTH_HI)) begin
            got_kata = 1'b1;
         end else begin
            got_other = 1'b1;
         end
      endfunction

      function void close_sequence();
         bit legal;
         case (seq_len)
            2'd1: legal = cp_acc >= uwsc_pkg::MIN_TWO_BYTE;
            2'd2: legal = cp_acc >= uwsc_pkg::MIN_THREE_BYTE &&
                          !(cp_acc >= uwsc_pkg::SURROGATE_LO &&
                            cp_acc <= uwsc_pkg::SURROGATE_HI);
            default: legal = cp_acc >= uwsc_pkg::MIN_FOUR_BYTE &&
                             cp_acc <= uwsc_pkg::MAX_CODEPOINT;
         endcase
         if (legal) begin
            sort_cp(cp_acc);
         end else begin
            flag_malformed();
         end
         seq_len = '0;
         cp_acc  = '0;
      endfunction

      function void note_byte(logic [7:0] b, logic last);
         word_verdict_type v;
         if (b[7:6] == 2'b10) begin
            if (pend_cnt == 0) begin
               flag_malformed();
            end else begin
               cp_acc   = {cp_acc[14:0], b[5:0]};
               pend_cnt = pend_cnt - 2'd1;
               if (pend_cnt == 0) begin
                  close_sequence();
               end
            end
         end else begin
            if (pend_cnt != 0) begin
               flag_malformed();
               pend_cnt = '0;
               seq_len  = '0;
               cp_acc   = '0;
            end
            if (!b[7]) begin
               sort_cp({13'd0, b});
            end else if (b[7:5] == 3'b110) begin
               pend_cnt = 2'd1;
               seq_len  = 2'd1;
               cp_acc   = {16'd0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
               pend_cnt = 2'd2;
               seq_len  = 2'd2;
               cp_acc   = {17'd0, b[3:0]};
            end else if (b[7:3] == 5'b11110) begin
               pend_cnt = 2'd3;
               seq_len  = 2'd3;
               cp_acc   = {18'd0, b[2:0]};
            end else begin
               flag_malformed();
            end
         end
         if (last) begin
            if (pend_cnt != 0) begin
               flag_malformed();
            end
            v.bad_encoding = got_bad;
            v.script_class = uwsc_pkg::CLASS_OTHER;
            if (!got_other && got_hira && !got_kata) begin
               v.script_class = uwsc_pkg::CLASS_HIRAGANA;
            end else if (!got_other && got_kata && !got_hira) begin
               v.script_class = uwsc_pkg::CLASS_KATAKANA;
            end
            expected_words.insert(expected_words.size(), v);
            reset_word();
         end
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      task report(string what);
         $display("ERROR at %0t: %s", $time, what);
         mismatch_count++;
      endtask

      task check_word_result(logic [1:0] cls, logic bad);
         word_verdict_type exp_v;
         if (expected_words.size() == 0) begin
            report("word result with no word outstanding");
            return;
         end
         exp_v = expected_words.pop_front();
         if (cls !== exp_v.script_class) begin
            report($sformatf("script_class %0d, expected %0d", cls, exp_v.script_class));
         end
         if (bad !== exp_v.bad_encoding) begin
            report($sformatf("bad_encoding %0b, expected %0b", bad, exp_v.bad_encoding));
         end
      endtask
   endclass

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_text_byte = 8'h00;
   logic       req_word_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_script_class;
   logic       rsp_bad_encoding;

   word_class_scoreboard words = new();
   logic [7:0] word_buf[$];
   int         byte_total = 0;
   int         word_total = 0;
   bit         quiet = 1'b0;
   bit         hold_request = 1'b0;

   int boundary_cps[18] = '{
      'h7F, 'h80, 'h7FF, 'h800, 'hFFFF, 'h10000, 'h10FFFF, 'h303F, 'h3100,
      'h31EF, 'h3200, 'hFF64, 'hFFA0, 'hD7FF, 'hE000, 'h30FB, 'h30FD, 'h309F
   };

   utf8_word_script_classifier i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .req_word_end     (req_word_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_script_class (rsp_script_class),
      .rsp_bad_encoding (rsp_bad_encoding)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic int idle_draw();
      return quiet ? 0 : $urandom_range(0, 3);
   endfunction

   function automatic void append_byte(input logic [7:0] b);
      word_buf.insert(word_buf.size(), b);
   endfunction

   function automatic int natural_len(input int cp);
      if (cp < uwsc_pkg::MIN_TWO_BYTE) return 1;
      if (cp < uwsc_pkg::MIN_THREE_BYTE) return 2;
      if (cp < uwsc_pkg::MIN_FOUR_BYTE) return 3;
      return 4;
   endfunction

   function automatic int pick_cp(input cp_group_type g);
      int r;
      int c;
      r = $urandom_range(0, 9);
      case (g)
         GROUP_HIRA: begin
            if (r == 0) return uwsc_pkg::HIRAGANA_LO;
            if (r == 1) return uwsc_pkg::HIRAGANA_HI;
            return $urandom_range(uwsc_pkg::HIRAGANA_LO, uwsc_pkg::HIRAGANA_HI);
         end
         GROUP_KATA: begin
            case (r % 3)
               0: return $urandom_range(uwsc_pkg::KATAKANA_LO, uwsc_pkg::KATAKANA_HI);
               1: return $urandom_range(uwsc_pkg::KATAKANA_EXT_LO,
                                        uwsc_pkg::KATAKANA_EXT_HI);
               default: return $urandom_range(uwsc_pkg::HALFWIDTH_LO,
                                              uwsc_pkg::HALFWIDTH_HI);
            endcase
         end
         GROUP_MARK: return uwsc_pkg::PROLONGED_MARK;
         default: begin
            case (r)
               0, 1: return $urandom_range(0, 'h7F);
               2: return $urandom_range('h80, 'h7FF);
               3: begin
                  c = $urandom_range('h800, 'hFFFF);
                  if (c >= uwsc_pkg::SURROGATE_LO && c <= uwsc_pkg::SURROGATE_HI) begin
                     c = c + 'h800;
                  end
                  return c;
               end
               4: return $urandom_range(uwsc_pkg::MIN_FOUR_BYTE, uwsc_pkg::MAX_CODEPOINT);
               5: return pick_cp(GROUP_HIRA);
               6: return pick_cp(GROUP_KATA);
               default: return boundary_cps[$urandom_range(0, 17)];
            endcase
         end
      endcase
   endfunction

   task automatic push_cp(input int cp, input int len);
      case (len)
         1: append_byte(8'(cp & 'h7F));
         2: begin
            append_byte(8'hC0 | 8'((cp >> 6) & 'h1F));
            append_byte(8'h80 | 8'(cp & 'h3F));
         end
         3: begin
            append_byte(8'hE0 | 8'((cp >> 12) & 'h0F));
            append_byte(8'h80 | 8'((cp >> 6) & 'h3F));
            append_byte(8'h80 | 8'(cp & 'h3F));
         end
         default: begin
            append_byte(8'hF0 | 8'((cp >> 18) & 'h07));
            append_byte(8'h80 | 8'((cp >> 12) & 'h3F));
            append_byte(8'h80 | 8'((cp >> 6) & 'h3F));
            append_byte(8'h80 | 8'(cp & 'h3F));
         end
      endcase
   endtask

   task automatic push_truncated();
      int len;
      int cp;
      len = $urandom_range(2, 4);
      case (len)
         2: cp = $urandom_range('h80, 'h7FF);
         3: cp = $urandom_range(uwsc_pkg::HIRAGANA_LO, uwsc_pkg::KATAKANA_HI);
         default: cp = $urandom_range(uwsc_pkg::MIN_FOUR_BYTE, uwsc_pkg::MAX_CODEPOINT);
      endcase
      push_cp(cp, len);
      repeat ($urandom_range(1, len - 1)) void'(word_buf.pop_back());
   endtask

   task automatic build_word();
      int             kind;
      int             n_cp;
      int             fault_at;
      int             len;
      int             cp;
      int             i;
      fault_kind_type fault;
      cp_group_type   main_group;
      cp_group_type   g;
      word_buf.delete();
      kind  = $urandom_range(0, 99);
      n_cp  = $urandom_range(1, 5);
      fault = FAULT_NONE;
      if (kind < 40) begin
         main_group = GROUP_HIRA;
      end else if (kind < 65) begin
         main_group = GROUP_KATA;
      end else begin
         main_group = GROUP_MIXED;
      end
      if (kind >= 95) begin
         fault = FAULT_NOISE;
      end else if (kind >= 80) begin
         fault = fault_kind_type'($urandom_range(FAULT_STRAY, FAULT_CUT_SHORT));
      end
      if (fault == FAULT_NOISE) begin
         repeat ($urandom_range(1, 6)) append_byte(8'($urandom));
         return;
      end
      fault_at = $urandom_range(0, n_cp - 1);
      for (i = 0; i < n_cp; i++) begin
         if (i == fault_at) begin
            case (fault)
               FAULT_STRAY: append_byte(8'($urandom_range('h80, 'hBF)));
               FAULT_BAD_LEAD: append_byte(8'($urandom_range('hF8, 'hFF)));
               FAULT_INTERRUPT: push_truncated();
               FAULT_OVERLONG: begin
                  len = $urandom_range(2, 4);
                  cp = $urandom_range(0, len == 2 ? 'h7F : len == 3 ? 'h7FF : 'hFFFF);
                  push_cp(cp, len);
               end
               FAULT_SURROGATE: push_cp($urandom_range(uwsc_pkg::SURROGATE_LO,
                                                       uwsc_pkg::SURROGATE_HI), 3);
               FAULT_ABOVE_MAX: push_cp($urandom_range(uwsc_pkg::MAX_CODEPOINT + 1,
                                                       'h1FFFFF), 4);
               default: ;
            endcase
         end
         g = main_group;
         if (main_group != GROUP_MIXED && $urandom_range(0, 5) == 0) g = GROUP_MARK;
         cp = pick_cp(g);
         push_cp(cp, natural_len(cp));
      end
      if (fault == FAULT_CUT_SHORT) push_truncated();
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= b;
      req_word_end  <= last;
      do @(posedge clock); while (req_stall);
      words.note_byte(b, last);
   endtask

   task automatic send_word();
      int n;
      int k;
      n = word_buf.size();
      for (k = 0; k < n; k++) begin
         send_byte(word_buf[k], k == n - 1);
      end
      byte_total += n;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (words.pending() != 0);
   endtask

   initial begin : result_sink
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (!reset && rsp_valid && !rsp_stall) begin
            words.check_word_result(rsp_script_class, rsp_bad_encoding);
            stall_left = idle_draw();
         end else if (stall_left > 0) begin
            stall_left--;
         end
         if (hold_left > 0) hold_left--;
         rsp_stall <= (stall_left > 0) || (hold_left > 0);
      end
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      word_buf = '{8'h00};
      send_word();
      word_buf = '{8'hE3, 8'h81, 8'h80};
      send_word();
      word_buf = '{8'hE3, 8'h83, 8'hBF};
      send_word();
      word_buf = '{8'hE3, 8'h83, 8'hBC};
      send_word();
      word_buf = '{8'h80};
      send_word();
      word_buf = '{8'hFF};
      send_word();
      word_buf = '{8'hE3, 8'h41};
      send_word();
      word_buf = '{8'hC0, 8'h80};
      send_word();
      word_buf = '{8'hED, 8'hA0, 8'h80};
      send_word();
      word_buf = '{8'hF4, 8'h90, 8'h80, 8'h80};
      send_word();
      word_buf = '{8'hE3, 8'h81};
      send_word();

      byte_total = 0;
      while (byte_total < RANDOM_BYTES) begin
         if (word_total == 30 || word_total == 150) hold_request = 1'b1;
         if (word_total == 90 || word_total == 180) wait_for_results();
         quiet = (word_total >= 120 && word_total < 150);
         build_word();
         send_word();
         word_total++;
      end

      wait_for_results();
      repeat (8) @(posedge clock);
      if (words.mismatch_count == 0 && words.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
